// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/fpgb_pkg.sv -----
// types and constants of the goertzel bank core
// no dependencies
`default_nettype none

package fpgb_pkg;

  localparam int NUM_BINS = 7;
  localparam int BIN_W    = 3;
  localparam int COEF_W   = 9;
  localparam int Q_W      = 16;
  localparam int BLEN_W   = 8;
  localparam int PW_W     = 8;
  localparam int ADDR_W   = 5;

  localparam logic [BIN_W-1:0]  LAST_BIN   = BIN_W'(NUM_BINS - 1);
  localparam logic [BIN_W-1:0]  REG_BLEN   = BIN_W'(NUM_BINS);
  localparam logic [BLEN_W-1:0] BLEN_RESET = 8'd100;

  localparam logic [COEF_W-1:0] COEF_RESET [NUM_BINS] = '{
    9'd228, 9'd222, 9'd214, 9'd206, 9'd175, 9'd158, 9'd138
  };

  localparam logic [7:0] SIGN_FLIP = 8'h80;
  localparam logic [7:0] X_CLAMP   = 8'h81;
  localparam logic [PW_W-1:0] PW_MAX = 8'd255;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SWEEP = 9'b000000010,
    S_PRD   = 9'b000000100,
    S_PAA   = 9'b000001000,
    S_PBB   = 9'b000010000,
    S_PAB   = 9'b000100000,
    S_PTC   = 9'b001000000,
    S_PFIN  = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

endpackage

`default_nettype wire

// ----- sv/fixed_point_goertzel_bank_core.sv -----
// seven-bin fixed-point goertzel bank, delay state held in one memory
// depends on fpgb_pkg
//
//  channel | handshake                   | payload
//  in      | in_valid / in_stall         | in_sample_byte
//  out     | out_valid / out_stall       | out_power_bin0..6
//  cfg     | psel penable pwrite pready  | paddr pwdata prdata
//
// a sample item is accepted only in idle; the next accept waits until the
// sweep ends: the state memory read port is swept once per bin through a
// 3-stage read/multiply/write pipeline. the last sample of a block adds a
// power pass per bin on the shared multiplier and an emit state for the result.
// reset clears the delay state at once through per-entry valid bits.
// a held result stalls only the next block end, not sample items.
`default_nettype none

module fixed_point_goertzel_bank_core
  import fpgb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [7:0]        in_sample_byte,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [PW_W-1:0]        out_power_bin0,
  output logic [PW_W-1:0]        out_power_bin1,
  output logic [PW_W-1:0]        out_power_bin2,
  output logic [PW_W-1:0]        out_power_bin3,
  output logic [PW_W-1:0]        out_power_bin4,
  output logic [PW_W-1:0]        out_power_bin5,
  output logic [PW_W-1:0]        out_power_bin6,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  state_t state_r, state_nxt;

  // delay memory: {q1, q2} per bin
  logic [2*Q_W-1:0]   qmem [NUM_BINS];
  logic [NUM_BINS-1:0] vld_r;
  logic [2*Q_W-1:0]   qrd_r;

  // coefficient memory
  logic [COEF_W-1:0]  cmem [NUM_BINS];
  logic [NUM_BINS-1:0] cvld_r;
  logic [COEF_W-1:0]  coef_q_r;
  logic [BLEN_W-1:0]  blen_r;
  logic [31:0]        prdata_r;

  logic [BLEN_W-1:0]  cnt_r;
  logic               last_r;
  logic signed [7:0]  x_r;

  logic [BIN_W-1:0]   iss_r, bin1_r, bin2_r, pbin_r;
  logic               iss_act_r, v1_r, v2_r;
  logic [BIN_W-1:0]   rd_addr;

  logic signed [Q_W-1:0] q1_s2_r, q2_s2_r, a_r, b_r;
  logic signed [24:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [41:0] prod_r;
  logic [31:0]        acc_r;
  logic [PW_W-1:0]    pw_r [NUM_BINS];
  logic [PW_W-1:0]    opw_r [NUM_BINS];
  logic               out_valid_r;

  logic               in_acc, cfg_we, qwe, out_free, emit;
  logic [BIN_W-1:0]   cfg_idx;
  logic [BLEN_W-1:0]  cnt_inc;
  logic signed [Q_W-1:0] rd_q1, rd_q2, q0;
  logic signed [41:0] prod_tr;
  logic [31:0]        e_val, e_adj;
  logic [Q_W-1:0]     p16;
  logic [PW_W-1:0]    pw_val;
  logic [7:0]         x_raw;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_we    = psel && penable && pwrite;
  assign cfg_idx   = paddr[ADDR_W-1:2];
  assign pready    = 1'b1;
  assign prdata    = prdata_r;
  assign cnt_inc   = cnt_r + BLEN_W'(1);
  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = (state_r == S_EMIT) && out_free;
  assign qwe       = (state_r == S_SWEEP) && v2_r;
  assign rd_q1     = qrd_r[2*Q_W-1:Q_W];
  assign rd_q2     = qrd_r[Q_W-1:0];
  assign x_raw     = in_sample_byte ^ SIGN_FLIP;

  // truncate toward zero on divide by 128
  assign prod_tr   = (prod_r + (prod_r[41] ? 42'sd127 : 42'sd0)) >>> 7;
  assign q0        = Q_W'(x_r) + prod_tr[Q_W-1:0] - q2_s2_r;

  // power: divide by 32768 toward zero, wrap to 16 bits, clamp
  assign e_val     = acc_r - prod_r[31:0];
  assign e_adj     = e_val + (e_val[31] ? 32'd32767 : 32'd0);
  assign p16       = e_adj[30:15];
  always_comb begin
    if (p16[Q_W-1]) begin
      pw_val = '0;
    end else if (p16[Q_W-2:PW_W] != '0) begin
      pw_val = PW_MAX;
    end else begin
      pw_val = p16[PW_W-1:0];
    end
  end

  always_comb begin
    if (state_r == S_SWEEP) begin
      rd_addr = iss_r;
    end else begin
      rd_addr = pbin_r;
    end
  end

  // shared multiplier operands
  always_comb begin
    unique case (state_r)
      S_SWEEP: begin
        mul_a = 25'(rd_q1);
        mul_b = {8'b0, coef_q_r};
      end
      S_PAA: begin
        mul_a = 25'(rd_q1);
        mul_b = 17'(rd_q1);
      end
      S_PBB: begin
        mul_a = 25'(b_r);
        mul_b = 17'(b_r);
      end
      S_PAB: begin
        mul_a = 25'(a_r);
        mul_b = 17'(b_r);
      end
      S_PTC: begin
        mul_a = prod_tr[24:0];
        mul_b = {8'b0, coef_q_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_SWEEP;
      S_SWEEP: begin
        if (v2_r && (bin2_r == LAST_BIN)) begin
          state_nxt = last_r ? S_PRD : S_IDLE;
        end
      end
      S_PRD:   state_nxt = S_PAA;
      S_PAA:   state_nxt = S_PBB;
      S_PBB:   state_nxt = S_PAB;
      S_PAB:   state_nxt = S_PTC;
      S_PTC:   state_nxt = S_PFIN;
      S_PFIN:  state_nxt = (pbin_r == LAST_BIN) ? S_EMIT : S_PRD;
      S_EMIT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (qwe) begin
      qmem[bin2_r] <= {q0, q1_s2_r};
    end
    qrd_r    <= vld_r[rd_addr] ? qmem[rd_addr] : '0;
    coef_q_r <= cvld_r[rd_addr] ? cmem[rd_addr] : COEF_RESET[rd_addr];
    if (cfg_we && (cfg_idx != REG_BLEN)) begin
      cmem[cfg_idx] <= pwdata[COEF_W-1:0];
    end
    if (cfg_idx == REG_BLEN) begin
      prdata_r <= {24'b0, blen_r};
    end else begin
      prdata_r <= {23'b0, cvld_r[cfg_idx] ? cmem[cfg_idx] : COEF_RESET[cfg_idx]};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vld_r       <= '0;
      cvld_r      <= '0;
      blen_r      <= BLEN_RESET;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      iss_r       <= '0;
      iss_act_r   <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      pbin_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_idx == REG_BLEN) begin
          blen_r <= pwdata[BLEN_W-1:0];
        end else begin
          cvld_r[cfg_idx] <= 1'b1;
        end
      end
      if (in_acc) begin
        last_r    <= (cnt_inc >= blen_r);
        cnt_r     <= (cnt_inc >= blen_r) ? '0 : cnt_inc;
        iss_r     <= '0;
        iss_act_r <= 1'b1;
        v1_r      <= 1'b0;
        v2_r      <= 1'b0;
        pbin_r    <= '0;
      end else if (state_r == S_SWEEP) begin
        v1_r <= iss_act_r;
        v2_r <= v1_r;
        if (iss_act_r) begin
          if (iss_r == LAST_BIN) begin
            iss_act_r <= 1'b0;
          end else begin
            iss_r <= iss_r + BIN_W'(1);
          end
        end
      end
      if (qwe) begin
        vld_r[bin2_r] <= 1'b1;
      end
      if (state_r == S_PFIN) begin
        if (pbin_r == LAST_BIN) begin
          vld_r <= '0;
        end else begin
          pbin_r <= pbin_r + BIN_W'(1);
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    bin1_r <= iss_r;
    bin2_r <= bin1_r;
    if (in_acc) begin
      x_r <= (in_sample_byte == '0) ? $signed(X_CLAMP) : $signed(x_raw);
    end
    if (state_r == S_SWEEP) begin
      q1_s2_r <= rd_q1;
      q2_s2_r <= rd_q2;
    end
    if (state_r == S_PAA) begin
      a_r <= rd_q1;
      b_r <= rd_q2;
    end
    if (state_r == S_PBB) begin
      acc_r <= prod_r[31:0];
    end
    if (state_r == S_PAB) begin
      acc_r <= acc_r + prod_r[31:0];
    end
    if (state_r == S_PFIN) begin
      pw_r[pbin_r] <= pw_val;
    end
    if (emit) begin
      opw_r <= pw_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_power_bin0 = opw_r[0];
  assign out_power_bin1 = opw_r[1];
  assign out_power_bin2 = opw_r[2];
  assign out_power_bin3 = opw_r[3];
  assign out_power_bin4 = opw_r[4];
  assign out_power_bin5 = opw_r[5];
  assign out_power_bin6 = opw_r[6];

endmodule

`default_nettype wire

// ----- sv/fpgb_checker.sv -----
// port-level checks of the goertzel bank core, bound to the top level
// depends on fpgb_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module fpgb_checker
  import fpgb_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [PW_W-1:0]   out_power_bin0
);

  `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_power_bin0), "held item dropped")
  `ASSERT_CLK(a_busy_after_accept, clk, rst_n, in_valid && !in_stall |=> in_stall, "not busy after accept")
  `ASSERT_CLK(a_result_from_work, clk, rst_n, $rose(out_valid) |-> $past(in_stall), "result without work")
  `ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid, "out_valid set after reset")

endmodule

bind fixed_point_goertzel_bank_core fpgb_checker u_fpgb_checker (.*);

`default_nettype wire

// ----- tb/testbench.sv -----
// self-checking testbench for fixed_point_goertzel_bank_core: random and directed sample items
// with a bit-exact goertzel power predictor, handshake idling, backpressure and register writes
// depends on fpgb_pkg and the core
`default_nettype none

module testbench;
  import fpgb_pkg::*;

  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 64;
  localparam int PHASES       = 11;
  localparam int PHASE_ITEMS  = 155;

  typedef logic [NUM_BINS-1:0][PW_W-1:0] power_set_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_sample_byte = 8'd0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [PW_W-1:0]   out_power_bin0, out_power_bin1, out_power_bin2, out_power_bin3;
  logic [PW_W-1:0]   out_power_bin4, out_power_bin5, out_power_bin6;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = 32'd0;
  logic [31:0]       prdata;
  logic              pready;

  logic hold_toggle = 1'b0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   error_count = 0;

  // bank mirror
  int acc1 [NUM_BINS];
  int acc2 [NUM_BINS];
  int coef_mirror [NUM_BINS];
  int blen_mirror;
  int block_count;
  power_set_t pending_powers [$];

  fixed_point_goertzel_bank_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_byte (in_sample_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_power_bin0 (out_power_bin0),
    .out_power_bin1 (out_power_bin1),
    .out_power_bin2 (out_power_bin2),
    .out_power_bin3 (out_power_bin3),
    .out_power_bin4 (out_power_bin4),
    .out_power_bin5 (out_power_bin5),
    .out_power_bin6 (out_power_bin6),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #2 clk = ~clk;

  function automatic int to_s16(longint v);
    logic [15:0] w;
    w = v[15:0];
    return int'($signed(w));
  endfunction

  function automatic int to_s32(longint v);
    logic [31:0] w;
    w = v[31:0];
    return int'($signed(w));
  endfunction

  function automatic logic [PW_W-1:0] bin_energy(int a, int b, int c);
    longint t;
    longint s;
    int p;
    t = (longint'(a) * longint'(b)) / 128;
    s = longint'(a) * longint'(a) + longint'(b) * longint'(b) - t * longint'(c);
    p = to_s16(longint'(to_s32(s) / 32768));
    if (p < 0) p = 0;
    if (p > int'(PW_MAX)) p = int'(PW_MAX);
    return p[PW_W-1:0];
  endfunction

  function automatic void advance_bank(logic [7:0] b);
    int x;
    int k;
    longint fb;
    int q0;
    power_set_t ps;
    x = int'(b) - 128;
    if (x == -128) x = -127;
    for (k = 0; k < NUM_BINS; k++) begin
      fb = (longint'(acc1[k]) * longint'(coef_mirror[k])) / 128;
      q0 = to_s16(longint'(x) + fb - longint'(acc2[k]));
      acc2[k] = acc1[k];
      acc1[k] = q0;
    end
    block_count = (block_count + 1) & 255;
    if (block_count < blen_mirror) return;
    for (k = 0; k < NUM_BINS; k++) begin
      ps[k] = bin_energy(acc1[k], acc2[k], coef_mirror[k]);
      acc1[k] = 0;
      acc2[k] = 0;
    end
    block_count = 0;
    pending_powers.push_back(ps);
  endfunction

  function automatic logic [7:0] pick_sample(int amp);
    int r;
    int lo;
    int hi;
    r = $urandom_range(19);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    lo = 128 - amp;
    hi = 128 + amp;
    if (lo < 0) lo = 0;
    if (hi > 255) hi = 255;
    return 8'($urandom_range(hi, lo));
  endfunction

  function automatic logic [31:0] pick_coef();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'd256;
    if (r == 2) return ($urandom & 32'hFFFF_FE00) | 32'($urandom_range(511));
    return 32'($urandom_range(256));
  endfunction

  function automatic logic [31:0] pick_blen();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'd255;
    if (r == 2) return 32'($urandom_range(255));
    return 32'($urandom_range(24, 1));
  endfunction

  // all tasks start and end at a rising edge
  task automatic send_sample(input logic [7:0] b);
    logic stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_sample_byte <= 8'($urandom);
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_byte <= b;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    advance_bank(b);
  endtask

  task automatic write_reg(input int idx, input logic [31:0] val);
    logic ready;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = pready;
      @(posedge clk);
    end while (!ready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (idx < NUM_BINS) coef_mirror[idx] = int'(val[COEF_W-1:0]);
    else if (idx == int'(REG_BLEN)) blen_mirror = int'(val[BLEN_W-1:0]);
  endtask

  task automatic settle_bank();
    in_valid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 86; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 86; end
      default: begin send_idle_pct = 34; stall_pct = 34; end
    endcase
  endtask

  task automatic test_default_block();
    int i;
    set_idling(0);
    for (i = 0; i < int'(BLEN_RESET); i++) send_sample(pick_sample(64));
    settle_bank();
  endtask

  task automatic test_short_blocks();
    write_reg(int'(REG_BLEN), 32'd1);
    send_sample(8'd0);
    send_sample(8'd1);
    send_sample(8'd127);
    send_sample(8'd128);
    send_sample(8'd129);
    send_sample(8'd255);
    settle_bank();
    write_reg(int'(REG_BLEN), 32'd0);
    send_sample(8'd200);
    send_sample(8'd55);
    settle_bank();
  endtask

  task automatic test_coef_extremes();
    int k;
    write_reg(int'(REG_BLEN), 32'd4);
    for (k = 0; k < NUM_BINS; k++) write_reg(k, 32'hFFFF_FE00 | 32'd511);
    send_sample(8'd255);
    send_sample(8'd0);
    send_sample(8'd255);
    send_sample(8'd0);
    settle_bank();
    for (k = 0; k < NUM_BINS; k++) write_reg(k, (k % 2 == 0) ? 32'd0 : 32'd256);
    send_sample(8'd0);
    send_sample(8'd255);
    send_sample(8'd0);
    send_sample(8'd255);
    settle_bank();
  endtask

  task automatic test_midblock_changes();
    int i;
    int k;
    write_reg(int'(REG_BLEN), 32'd6);
    for (i = 0; i < 3; i++) send_sample(pick_sample(128));
    settle_bank();
    for (k = 0; k < NUM_BINS; k++) write_reg(k, pick_coef());
    for (i = 0; i < 3; i++) send_sample(pick_sample(128));
    settle_bank();
    write_reg(int'(REG_BLEN), 32'd8);
    for (i = 0; i < 5; i++) send_sample(pick_sample(32));
    settle_bank();
    // counter already past the new length
    write_reg(int'(REG_BLEN), 32'd3);
    send_sample(pick_sample(32));
    settle_bank();
  endtask

  task automatic test_backpressure();
    int i;
    set_idling(0);
    write_reg(int'(REG_BLEN), 32'd1);
    hold_toggle <= ~hold_toggle;
    for (i = 0; i < 12; i++) send_sample(pick_sample(128));
    settle_bank();
  endtask

  task automatic test_random_phases();
    int ph;
    int i;
    int k;
    int amp;
    for (ph = 0; ph < PHASES; ph++) begin
      set_idling(ph % 4);
      for (k = 0; k < NUM_BINS; k++) write_reg(k, pick_coef());
      write_reg(int'(REG_BLEN), pick_blen());
      case (ph % 5)
        0: amp = 1;
        1: amp = 4;
        2: amp = 16;
        3: amp = 64;
        default: amp = 128;
      endcase
      for (i = 0; i < PHASE_ITEMS; i++) send_sample(pick_sample(amp));
      settle_bank();
    end
  endtask

  // receiver
  initial begin
    logic seen;
    int n;
    seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != seen) begin
        seen = hold_toggle;
        for (n = 0; n < HOLD_CYCLES; n++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end
  end

  always @(negedge clk) begin : check_result
    power_set_t got;
    power_set_t want;
    int k;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_power_bin6, out_power_bin5, out_power_bin4, out_power_bin3,
             out_power_bin2, out_power_bin1, out_power_bin0};
      if (pending_powers.size() == 0) begin
        $error("result item with no block pending");
        error_count++;
      end else begin
        want = pending_powers.pop_front();
        for (k = 0; k < NUM_BINS; k++) begin
          if (got[k] !== want[k]) begin
            $error("power_bin%0d expected %0d got %0d", k, want[k], got[k]);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int k;
    for (k = 0; k < NUM_BINS; k++) begin
      acc1[k] = 0;
      acc2[k] = 0;
      coef_mirror[k] = int'(COEF_RESET[k]);
    end
    blen_mirror = int'(BLEN_RESET);
    block_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_block();
    test_short_blocks();
    test_coef_extremes();
    test_midblock_changes();
    test_backpressure();
    test_random_phases();
    settle_bank();
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
